@@ rtl/core/line_assembler_drop_oldest_queue_defines.svh @@
// assertion macros for the line assembler checker
`ifndef LINE_ASSEMBLER_DROP_OLDEST_QUEUE_DEFINES_SVH
`define LINE_ASSEMBLER_DROP_OLDEST_QUEUE_DEFINES_SVH

// same-cycle implication
`define LADQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LADQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ladq_pkg.sv @@
// shared types and constants of the line assembler
package ladq_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SERIAL_EN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IR_EN     = 1'b1;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    typedef enum logic [1:0] {
        CMD_SERIAL = 2'd0,
        CMD_IR     = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_DECODE  = 3'd1,
        ST_PUSH    = 3'd2,
        ST_POOL_RD = 3'd3,
        ST_FINISH  = 3'd4
    } state_t;

    typedef struct packed {
        logic latch_item;
        logic append_byte;
        logic push_serial;
        logic push_remote;
        logic deliver_remote;
        logic deliver_pool;
        logic load_result;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic serial_en;
        logic ir_en;
        logic is_term;
        logic len_zero;
        logic len_full;
        logic code_nonzero;
        logic queue_nonempty;
        logic head_remote;
        logic res_free;
    } stat_t;

endpackage

@@ rtl/core/ladq_ram.sv @@
// generic simple dual-port ram with registered read
module ladq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ladq_ctrl.sv @@
// sequencer of the line assembler: one item at a time
module ladq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ladq_pkg::stat_t stat,
    output ladq_pkg::ctrl_t ctrl
);

    ladq_pkg::state_t state_reg;
    ladq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ladq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ladq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.latch_item = 1'b1;
                    state_next      = ladq_pkg::ST_DECODE;
                end
            end
            ladq_pkg::ST_DECODE:
            begin
                state_next = ladq_pkg::ST_FINISH;
                unique case (stat.cmd)
                    ladq_pkg::CMD_SERIAL:
                    begin
                        if (stat.serial_en)
                        begin
                            if (stat.is_term)
                            begin
                                if (!stat.len_zero)
                                begin
                                    state_next = ladq_pkg::ST_PUSH;
                                end
                            end
                            else if (!stat.len_full)
                            begin
                                ctrl.append_byte = 1'b1;
                            end
                        end
                    end
                    ladq_pkg::CMD_IR:
                    begin
                        if (stat.ir_en && stat.code_nonzero)
                        begin
                            state_next = ladq_pkg::ST_PUSH;
                        end
                    end
                    ladq_pkg::CMD_READ:
                    begin
                        if (stat.queue_nonempty)
                        begin
                            if (stat.head_remote)
                            begin
                                ctrl.deliver_remote = 1'b1;
                            end
                            else
                            begin
                                state_next = ladq_pkg::ST_POOL_RD;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ladq_pkg::ST_FINISH;
                    end
                endcase
            end
            ladq_pkg::ST_PUSH:
            begin
                if (stat.cmd == ladq_pkg::CMD_SERIAL)
                begin
                    ctrl.push_serial = 1'b1;
                end
                else
                begin
                    ctrl.push_remote = 1'b1;
                end
                state_next = ladq_pkg::ST_FINISH;
            end
            ladq_pkg::ST_POOL_RD:
            begin
                ctrl.deliver_pool = 1'b1;
                state_next        = ladq_pkg::ST_FINISH;
            end
            ladq_pkg::ST_FINISH:
            begin
                if (stat.res_free)
                begin
                    ctrl.load_result = 1'b1;
                    state_next       = ladq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ladq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/ladq_datapath.sv @@
// line assembler datapath: byte pool, line queue, pointers and result register
module ladq_datapath #(
    parameter int MAX_LINE    = 128,
    parameter int QUEUE_LINES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ladq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ladq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          command,
    input  logic [7:0]                          in_byte,
    input  logic                                res_stall,
    input  ladq_pkg::ctrl_t                     ctrl,
    output ladq_pkg::stat_t                     stat,
    output logic                                res_valid,
    output logic                                out_valid,
    output logic [7:0]                          out_byte,
    output logic                                out_last,
    output logic [$clog2(QUEUE_LINES+1)-1:0]    lines_waiting
);

    localparam int NUM_SLOTS  = QUEUE_LINES + 1;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int LEN_W      = $clog2(MAX_LINE + 1);
    localparam int CUR_W      = $clog2(MAX_LINE);
    localparam int HEAD_W     = $clog2(QUEUE_LINES);
    localparam int CNT_W      = $clog2(QUEUE_LINES + 1);
    localparam int SUM_W      = $clog2(2 * QUEUE_LINES);
    localparam int POOL_DEPTH = NUM_SLOTS * MAX_LINE;
    localparam int POOL_AW    = $clog2(POOL_DEPTH);
    localparam int ENT_W      = SLOT_W + LEN_W + 1 + 8;

    // item and configuration
    logic [1:0]            cmd_reg, cmd_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  serial_en_reg, serial_en_next;
    logic                  ir_en_reg, ir_en_next;

    // line build and queue pointers
    logic [SLOT_W-1:0]     accum_slot_reg, accum_slot_next;
    logic [LEN_W-1:0]      accum_len_reg, accum_len_next;
    logic [NUM_SLOTS-1:0]  free_map_reg, free_map_next;
    logic [HEAD_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CUR_W-1:0]      cursor_reg, cursor_next;

    // pending and delivered result
    logic                  pend_valid_reg, pend_valid_next;
    logic [7:0]            pend_byte_reg, pend_byte_next;
    logic                  pend_last_reg, pend_last_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;
    logic [CNT_W-1:0]      lines_reg, lines_next;

    // memories
    logic                  pool_we;
    logic [POOL_AW-1:0]    pool_waddr;
    logic [POOL_AW-1:0]    pool_raddr;
    logic [7:0]            pool_q;
    logic                  ent_we;
    logic [HEAD_W-1:0]     ent_waddr;
    logic [ENT_W-1:0]      ent_wdata;
    logic [ENT_W-1:0]      ent_q;

    logic [SLOT_W-1:0]     ent_slot;
    logic [LEN_W-1:0]      ent_len;
    logic                  ent_remote;
    logic [7:0]            ent_code;

    logic [SUM_W-1:0]      head_plus;
    logic [SUM_W-1:0]      tail_wrap;
    logic [HEAD_W-1:0]     head_inc;
    logic                  q_full;
    logic [LEN_W-1:0]      cur_inc;
    logic                  is_last;
    logic                  do_push;
    logic                  do_deliver;
    logic                  do_pop;
    logic [NUM_SLOTS-1:0]  pop_mask;
    logic [NUM_SLOTS-1:0]  map_base;
    logic [NUM_SLOTS-1:0]  map_low;
    logic [SLOT_W-1:0]     free_idx;

    assign ent_slot   = ent_q[ENT_W-1 -: SLOT_W];
    assign ent_len    = ent_q[LEN_W+8 -: LEN_W];
    assign ent_remote = ent_q[8];
    assign ent_code   = ent_q[7:0];

    assign head_plus = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (head_plus >= SUM_W'(QUEUE_LINES)) ?
                       head_plus - SUM_W'(QUEUE_LINES) : head_plus;
    assign head_inc  = (head_reg == HEAD_W'(QUEUE_LINES - 1)) ? '0 : head_reg + 1'b1;
    assign q_full    = (count_reg == CNT_W'(QUEUE_LINES));
    assign cur_inc   = LEN_W'(cursor_reg) + 1'b1;
    assign is_last   = (cur_inc >= ent_len);

    assign do_push    = ctrl.push_serial || ctrl.push_remote;
    assign do_deliver = ctrl.deliver_remote || ctrl.deliver_pool;
    assign do_pop     = (do_push && q_full) || (do_deliver && is_last);
    assign pop_mask   = (do_pop && !ent_remote) ? (NUM_SLOTS'(1) << ent_slot) : '0;
    assign map_base   = free_map_reg | pop_mask;
    // isolate the lowest free slot
    assign map_low    = map_base & (~map_base + 1'b1);

    always_comb
    begin
        free_idx = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (map_low[s])
            begin
                free_idx = free_idx | SLOT_W'(s);
            end
        end
    end

    assign pool_we    = ctrl.append_byte;
    assign pool_waddr = POOL_AW'(accum_slot_reg) * POOL_AW'(MAX_LINE)
                      + POOL_AW'(accum_len_reg);
    assign pool_raddr = POOL_AW'(ent_slot) * POOL_AW'(MAX_LINE) + POOL_AW'(cursor_reg);

    assign ent_we    = do_push;
    assign ent_waddr = HEAD_W'(tail_wrap);
    assign ent_wdata = ctrl.push_serial ?
                       {accum_slot_reg, accum_len_reg, 1'b0, 8'h00} :
                       {SLOT_W'(0), LEN_W'(1), 1'b1, byte_reg};

    ladq_ram #(
        .WIDTH (8),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (byte_reg),
        .raddr (pool_raddr),
        .rdata (pool_q)
    );

    ladq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_LINES)
    ) u_entries (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (head_reg),
        .rdata (ent_q)
    );

    always_comb
    begin
        cmd_next        = cmd_reg;
        byte_next       = byte_reg;
        serial_en_next  = serial_en_reg;
        ir_en_next      = ir_en_reg;
        accum_slot_next = accum_slot_reg;
        accum_len_next  = accum_len_reg;
        free_map_next   = map_base;
        head_next       = head_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_last_next  = pend_last_reg;
        res_valid_next  = res_valid_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        lines_next      = lines_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                ladq_pkg::REG_SERIAL_EN: serial_en_next = cfg_data[0];
                ladq_pkg::REG_IR_EN:     ir_en_next     = cfg_data[0];
            endcase
        end

        if (ctrl.latch_item)
        begin
            cmd_next        = command;
            byte_next       = in_byte;
            pend_valid_next = 1'b0;
            pend_byte_next  = 8'h00;
            pend_last_next  = 1'b0;
        end

        if (ctrl.append_byte)
        begin
            accum_len_next = accum_len_reg + 1'b1;
        end

        if (do_pop)
        begin
            head_next   = head_inc;
            cursor_next = '0;
        end

        if (do_push)
        begin
            if (!q_full)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (ctrl.push_serial)
        begin
            accum_len_next = '0;
            free_map_next  = map_base & ~map_low;
            if (map_base != '0)
            begin
                accum_slot_next = free_idx;
            end
        end

        if (do_deliver)
        begin
            pend_valid_next = 1'b1;
            pend_byte_next  = ctrl.deliver_remote ? ent_code : pool_q;
            pend_last_next  = is_last;
            if (is_last)
            begin
                count_next = count_reg - 1'b1;
            end
            else
            begin
                cursor_next = CUR_W'(cur_inc);
            end
        end

        if (ctrl.load_result)
        begin
            res_valid_next = 1'b1;
            out_valid_next = pend_valid_reg;
            out_byte_next  = pend_byte_reg;
            out_last_next  = pend_last_reg;
            lines_next     = count_reg;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_en_reg  <= 1'b0;
            ir_en_reg      <= 1'b1;
            accum_slot_reg <= '0;
            accum_len_reg  <= '0;
            free_map_reg   <= {{(NUM_SLOTS-1){1'b1}}, 1'b0};
            head_reg       <= '0;
            count_reg      <= '0;
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            serial_en_reg  <= serial_en_next;
            ir_en_reg      <= ir_en_next;
            accum_slot_reg <= accum_slot_next;
            accum_len_reg  <= accum_len_next;
            free_map_reg   <= free_map_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            cursor_reg     <= cursor_next;
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        byte_reg      <= byte_next;
        pend_byte_reg <= pend_byte_next;
        out_valid_reg <= out_valid_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        lines_reg     <= lines_next;
    end

    assign stat.cmd            = ladq_pkg::cmd_t'(cmd_reg);
    assign stat.serial_en      = serial_en_reg;
    assign stat.ir_en          = ir_en_reg;
    assign stat.is_term        = (byte_reg == ladq_pkg::CH_LF) || (byte_reg == ladq_pkg::CH_CR);
    assign stat.len_zero       = (accum_len_reg == '0);
    assign stat.len_full       = (accum_len_reg == LEN_W'(MAX_LINE));
    assign stat.code_nonzero   = (byte_reg != 8'h00);
    assign stat.queue_nonempty = (count_reg != '0);
    assign stat.head_remote    = ent_remote;
    assign stat.res_free       = !res_valid_reg || !res_stall;

    assign res_valid     = res_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_last      = out_last_reg;
    assign lines_waiting = lines_reg;

endmodule

@@ rtl/core/line_assembler_drop_oldest_queue.sv @@
// top level of the line assembler with drop-oldest line queue
//
// input channel in_valid/in_stall carries one beat per item: command (serial
// byte, remote code or read) and in_byte. every item gives exactly one result
// beat on res_valid/res_stall: out_valid, out_byte, out_last, lines_waiting.
// configuration: cfg_we with cfg_index selects serial enable or remote enable;
// write only while the block is idle.
// sequence: the input beat is latched in IDLE and the result register loads in
// FINISH, entered from DECODE for a stored byte, a remote-code read or an
// ignored item, and via PUSH for a line push or via POOL_RD, which waits on the
// registered pool read, for a pool read; the sequencer handles one item at a
// time, so a new beat is taken only once the last item's result is loaded.
// a stalled result holds its register; the sequencer still takes the next
// beat, works it and keeps its result pending with in_stall high until the
// stalled beat is taken.
// reset: queue empty, current line empty, serial input disabled, remote input
// enabled; the byte pool and line table need no clearing pass.
module line_assembler_drop_oldest_queue #(
    parameter int MAX_LINE    = 128,
    parameter int QUEUE_LINES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ladq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ladq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          command,
    input  logic [7:0]                          in_byte,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic                                out_valid,
    output logic [7:0]                          out_byte,
    output logic                                out_last,
    output logic [$clog2(QUEUE_LINES+1)-1:0]    lines_waiting
);

    ladq_pkg::ctrl_t ctrl;
    ladq_pkg::stat_t stat;

    ladq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ladq_datapath #(
        .MAX_LINE    (MAX_LINE),
        .QUEUE_LINES (QUEUE_LINES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .in_byte       (in_byte),
        .res_stall     (res_stall),
        .ctrl          (ctrl),
        .stat          (stat),
        .res_valid     (res_valid),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .lines_waiting (lines_waiting)
    );

endmodule

@@ rtl/core/ladq_checker.sv @@
// port checker for the line assembler, bound to the top level
`include "line_assembler_drop_oldest_queue_defines.svh"

module ladq_checker #(
    parameter int QUEUE_LINES = 16
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             res_valid,
    input logic                             res_stall,
    input logic                             out_valid,
    input logic [7:0]                       out_byte,
    input logic                             out_last,
    input logic [$clog2(QUEUE_LINES+1)-1:0] lines_waiting
);

    localparam int                LINES_W   = $clog2(QUEUE_LINES + 1);
    localparam logic [LINES_W-1:0] LINES_MAX = LINES_W'(QUEUE_LINES);

    // queue never reports more lines than it holds
    `LADQ_ASSERT_NOW(a_lines_bound, clk, rst_n, res_valid, lines_waiting <= LINES_MAX, "lines_waiting above queue depth")

    // a beat without data carries no byte and no last mark
    `LADQ_ASSERT_NOW(a_empty_beat, clk, rst_n, res_valid && !out_valid, out_byte == 8'h00 && !out_last, "empty result beat carries data")

    // one item at a time: an accepted beat blocks the input next cycle
    `LADQ_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while busy")

    // a stalled result beat holds
    `LADQ_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(out_valid) && $stable(out_byte) && $stable(out_last) && $stable(lines_waiting), "stalled result changed")

endmodule

bind line_assembler_drop_oldest_queue ladq_checker #(
    .QUEUE_LINES (QUEUE_LINES)
) u_ladq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .lines_waiting (lines_waiting)
);

@@ sim/line_assembler_drop_oldest_queue_tb.sv @@
// self-checking testbench of the line assembler with drop-oldest line queue
module line_assembler_drop_oldest_queue_tb;

    localparam int MAX_LINE    = 128;
    localparam int QUEUE_LINES = 16;
    localparam int POOL_SLOTS  = QUEUE_LINES + 1;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 95;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic [4:0] lines;
    } read_beat_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [ladq_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [1:0]                       cmd;
        logic [7:0]                       data;
        logic [7:0]                       reps;
        bit                               typed;
        read_beat_t                       want;
    } row_t;

    localparam read_beat_t QUIET_BEAT  = '0;
    localparam read_beat_t ONE_WAITING = '{1'b0, 8'h00, 1'b0, 5'd1};
    localparam read_beat_t REMOTE_FF   = '{1'b1, 8'hFF, 1'b1, 5'd0};

    localparam row_t DIRECTED [22] = '{
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_READ, 8'h00, 8'd1, 1'b1, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, 8'h41, 8'd1, 1'b1, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_IR, 8'h00, 8'd1, 1'b1, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_IR, 8'hFF, 8'd1, 1'b1, ONE_WAITING},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, CMD_SPARE, 8'hAA, 8'd1, 1'b1, ONE_WAITING},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_READ, 8'h00, 8'd1, 1'b1, REMOTE_FF},
        '{ROW_CFG, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, 8'h01, 8'd1, 1'b0, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, ladq_pkg::CH_LF, 8'd1, 1'b1,
          QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, 8'h00, 8'd1, 1'b0, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, 8'hFF, 8'd1, 1'b0, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, ladq_pkg::CH_CR, 8'd1, 1'b1,
          ONE_WAITING},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_READ, 8'h00, 8'd2, 1'b0, QUIET_BEAT},
        '{ROW_CFG, ladq_pkg::REG_IR_EN, ladq_pkg::CMD_SERIAL, 8'h00, 8'd1, 1'b0, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_IR, 8'h55, 8'd1, 1'b1, QUIET_BEAT},
        '{ROW_CFG, ladq_pkg::REG_IR_EN, ladq_pkg::CMD_SERIAL, 8'h01, 8'd1, 1'b0, QUIET_BEAT},
        // overlong line, tail bytes dropped
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, 8'h20, 8'd130, 1'b0, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, ladq_pkg::CH_LF, 8'd1, 1'b0,
          QUIET_BEAT},
        // part-read front line is dropped once the queue overflows
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_READ, 8'h00, 8'd3, 1'b0, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_IR, 8'h01, 8'd16, 1'b0, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_READ, 8'h00, 8'd17, 1'b0, QUIET_BEAT},
        '{ROW_CFG, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, 8'h00, 8'd1, 1'b0, QUIET_BEAT},
        '{ROW_ITEM, ladq_pkg::REG_SERIAL_EN, ladq_pkg::CMD_SERIAL, ladq_pkg::CH_LF, 8'd1, 1'b1,
          QUIET_BEAT}
    };

    localparam int PH_SERIAL    [PHASES] = '{1, 1, 1, 0, 1, 1};
    localparam int PH_IR        [PHASES] = '{1, 1, 0, 1, 1, 0};
    localparam int PH_SEND_IDLE [PHASES] = '{0, 65, 0, 25, 25, 0};
    localparam int PH_STALL     [PHASES] = '{0, 0, 65, 25, 25, 0};

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [ladq_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ladq_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [1:0]                       command = 2'd0;
    logic [7:0]                       in_byte = 8'd0;
    logic                             res_valid;
    logic                             res_stall = 1'b0;
    logic                             out_valid;
    logic [7:0]                       out_byte;
    logic                             out_last;
    logic [4:0]                       lines_waiting;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          live_items = 0;
    read_beat_t  beats_due [$];

    // predictor state
    logic [7:0]  pool_mem [POOL_SLOTS*MAX_LINE];
    bit          slot_free [POOL_SLOTS];
    int unsigned acc_slot = 0;
    int unsigned acc_len = 0;
    int unsigned line_slot [QUEUE_LINES];
    int unsigned line_len [QUEUE_LINES];
    bit          line_remote [QUEUE_LINES];
    logic [7:0]  line_code [QUEUE_LINES];
    int unsigned q_head = 0;
    int unsigned q_count = 0;
    int unsigned rd_pos = 0;
    bit          serial_on = 1'b0;
    bit          ir_on = 1'b1;

    line_assembler_drop_oldest_queue #(
        .MAX_LINE    (MAX_LINE),
        .QUEUE_LINES (QUEUE_LINES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .in_byte       (in_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .lines_waiting (lines_waiting)
    );

    always #1 clk = ~clk;

    function automatic void release_front();
        if (!line_remote[q_head] && line_slot[q_head] < POOL_SLOTS)
            slot_free[line_slot[q_head]] = 1'b1;
        q_head = (q_head + 1) % QUEUE_LINES;
        q_count--;
        rd_pos = 0;
    endfunction

    function automatic void queue_line(input int unsigned slot, input int unsigned len,
                                       input bit remote, input logic [7:0] code);
        int unsigned tail;
        if (q_count >= QUEUE_LINES)
            release_front();
        tail = (q_head + q_count) % QUEUE_LINES;
        line_slot[tail]   = slot;
        line_len[tail]    = len;
        line_remote[tail] = remote;
        line_code[tail]   = code;
        q_count++;
    endfunction

    // predicts the result beat of one item
    function automatic void assemble_step(input logic [1:0] cmd, input logic [7:0] data,
                                          output read_beat_t beat);
        int unsigned h;
        beat = '0;
        if (cmd == ladq_pkg::CMD_SERIAL && serial_on)
        begin
            if (data == ladq_pkg::CH_LF || data == ladq_pkg::CH_CR)
            begin
                if (acc_len != 0)
                begin
                    queue_line(acc_slot, acc_len, 1'b0, 8'h00);
                    for (int s = 0; s < POOL_SLOTS; s++)
                    begin
                        if (slot_free[s])
                        begin
                            slot_free[s] = 1'b0;
                            acc_slot = s;
                            break;
                        end
                    end
                    acc_len = 0;
                end
            end
            else if (acc_len < MAX_LINE)
            begin
                pool_mem[acc_slot * MAX_LINE + acc_len] = data;
                acc_len++;
            end
        end
        else if (cmd == ladq_pkg::CMD_IR && ir_on && data != 8'h00)
        begin
            queue_line(0, 1, 1'b1, data);
        end
        else if (cmd == ladq_pkg::CMD_READ)
        begin
            if (q_count > 0)
            begin
                h = q_head;
                beat.valid = 1'b1;
                beat.data = line_remote[h] ? line_code[h]
                                           : pool_mem[line_slot[h] * MAX_LINE + rd_pos];
                if (rd_pos + 1 >= line_len[h])
                begin
                    beat.last = 1'b1;
                    release_front();
                end
                else
                    rd_pos++;
            end
        end
        beat.lines = q_count[4:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                             input bit typed, input read_beat_t want);
        read_beat_t beat;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        in_byte  <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        assemble_step(cmd, data, beat);
        live_items++;
        beats_due.insert(beats_due.size(), typed ? want : beat);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_due.size() != 0);
    endtask

    task automatic write_reg(input logic [ladq_pkg::CFG_IDX_W-1:0] idx, input bit value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ladq_pkg::REG_SERIAL_EN)
            serial_on = value;
        else
            ir_on = value;
    endtask

    // result side: random stall and in-order compare
    always @(posedge clk)
    begin
        read_beat_t due;
        if (rst_n && res_valid && !res_stall)
        begin
            if (beats_due.size() == 0)
                report_mismatch("result beat with nothing due");
            else
            begin
                due = beats_due[0];
                beats_due.delete(0);
                if (out_valid !== due.valid)
                    report_mismatch($sformatf("out_valid %b, want %b", out_valid, due.valid));
                if (out_byte !== due.data)
                    report_mismatch($sformatf("out_byte %h, want %h", out_byte, due.data));
                if (out_last !== due.last)
                    report_mismatch($sformatf("out_last %b, want %b", out_last, due.last));
                if (lines_waiting !== due.lines)
                    report_mismatch($sformatf("lines_waiting %0d, want %0d",
                                              lines_waiting, due.lines));
            end
        end
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL line_assembler_drop_oldest_queue");
            $finish;
        end
    end

    initial
    begin
        int         len;
        int         r;
        int         target;
        logic [7:0] b;
        bit         paused;
        for (int s = 0; s < POOL_SLOTS; s++)
            slot_free[s] = (s != 0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].data[0]);
            else
                for (int k = 0; k < DIRECTED[i].reps; k++)
                    send_item(DIRECTED[i].cmd, DIRECTED[i].data + 8'(k),
                              DIRECTED[i].typed, DIRECTED[i].want);
        end

        live_items = 0;
        paused = 1'b0;
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(ladq_pkg::REG_SERIAL_EN, PH_SERIAL[p][0]);
            write_reg(ladq_pkg::REG_IR_EN, PH_IR[p][0]);
            send_idle_pct = PH_SEND_IDLE[p];
            stall_pct = PH_STALL[p];
            target = (p + 1) * PHASE_ITEMS;
            while (live_items < target)
            begin
                if (p == 4 && !paused && live_items > target - PHASE_ITEMS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                r = $urandom_range(99);
                if (r < 40)
                begin
                    // well-formed line, now and then overlong
                    len = ($urandom_range(19) == 0) ? $urandom_range(140, 120)
                                                    : $urandom_range(16, 1);
                    for (int k = 0; k < len; k++)
                    begin
                        b = 8'($urandom_range(255));
                        if (b == ladq_pkg::CH_LF || b == ladq_pkg::CH_CR)
                            b = b ^ 8'h40;
                        send_item(ladq_pkg::CMD_SERIAL, b, 1'b0, QUIET_BEAT);
                    end
                    send_item(ladq_pkg::CMD_SERIAL,
                              $urandom_range(1) ? ladq_pkg::CH_CR : ladq_pkg::CH_LF,
                              1'b0, QUIET_BEAT);
                end
                else if (r < 55)
                    send_item(ladq_pkg::CMD_IR, 8'($urandom_range(255, 1)), 1'b0, QUIET_BEAT);
                else if (r < 90)
                begin
                    len = $urandom_range(24, 1);
                    for (int k = 0; k < len; k++)
                        send_item(ladq_pkg::CMD_READ, 8'($urandom_range(255)), 1'b0,
                                  QUIET_BEAT);
                end
                else
                    for (int k = 0; k < 3; k++)
                        send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0,
                                  QUIET_BEAT);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS line_assembler_drop_oldest_queue");
        else
            $display("FAIL line_assembler_drop_oldest_queue");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ladq_pkg.sv
rtl/core/ladq_ram.sv
rtl/core/ladq_ctrl.sv
rtl/core/ladq_datapath.sv
rtl/core/line_assembler_drop_oldest_queue.sv
rtl/core/ladq_checker.sv
sim/line_assembler_drop_oldest_queue_tb.sv
